### rtl/led_digit_command_sequencer_core_macros.svh
// assertion macros shared by the checker files of the led digit sequencer
// no dependencies; each macro expects clk and rst_n in the using scope
`ifndef LED_DIGIT_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define LED_DIGIT_COMMAND_SEQUENCER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LDS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lds check failed");

// antecedent implies consequent in the next cycle
`define LDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lds check failed");

`endif

### rtl/lds_pkg.sv
// types, command constants and lookup functions of the led digit sequencer
// no dependencies
`timescale 1ns / 1ps

package lds_pkg;

    localparam int LDS_QUEUE_DEPTH = 4;

    localparam logic [7:0] CMD_FIXED_ADDR  = 8'h44;
    localparam logic [7:0] CMD_ADDR_BASE   = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h8F;
    localparam logic [7:0] CMD_BRIGHT_BASE = 8'h88;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h80;
    localparam logic [7:0] SEG_POINT       = 8'h80;
    localparam logic [7:0] SEG_BLANK       = 8'h00;

    typedef enum logic [1:0] {
        ACT_WRITE_DIGIT    = 2'd0,
        ACT_SHOW_NUMBER    = 2'd1,
        ACT_SET_BRIGHTNESS = 2'd2,
        ACT_DISPLAY_OFF    = 2'd3
    } lds_action_t;

    typedef enum logic {
        OP_DIGIT  = 1'b0,
        OP_SINGLE = 1'b1
    } lds_op_t;

    typedef enum logic [1:0] {
        STEP_MODE = 2'd0,
        STEP_ADDR = 2'd1,
        STEP_SEG  = 2'd2,
        STEP_ON   = 2'd3
    } lds_step_t;

    typedef enum logic {
        FS_IDLE   = 1'b0,
        FS_DIGITS = 1'b1
    } lds_front_state_t;

    // one queued command: a four-byte digit write or a single framed byte
    typedef struct packed {
        lds_op_t     op;
        logic [2:0]  addr;
        logic [7:0]  data;
        logic        last;
    } lds_entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } lds_q_status_t;

    function automatic logic [7:0] seg_lookup(input logic [4:0] sym);
        logic [7:0] code;
        case (sym)
            5'd0:    code = 8'h3F;
            5'd1:    code = 8'h06;
            5'd2:    code = 8'h5B;
            5'd3:    code = 8'h4F;
            5'd4:    code = 8'h66;
            5'd5:    code = 8'h6D;
            5'd6:    code = 8'h7D;
            5'd7:    code = 8'h07;
            5'd8:    code = 8'h7F;
            5'd9:    code = 8'h6F;
            5'd10:   code = 8'h77;
            5'd11:   code = 8'h7C;
            5'd12:   code = 8'h58;
            5'd13:   code = 8'h5E;
            5'd14:   code = 8'h79;
            5'd15:   code = 8'h71;
            5'd16:   code = 8'h76;
            5'd17:   code = 8'h38;
            5'd18:   code = 8'h54;
            5'd19:   code = 8'h73;
            5'd20:   code = 8'h3E;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

    function automatic logic [13:0] digit_weight(input logic [1:0] idx);
        logic [13:0] w;
        case (idx)
            2'd0:    w = 14'd1000;
            2'd1:    w = 14'd100;
            2'd2:    w = 14'd10;
            default: w = 14'd1;
        endcase
        return w;
    endfunction

endpackage

### rtl/lds_if.sv
// request and command byte channel interfaces of the led digit sequencer
// no dependencies
`timescale 1ns / 1ps

interface lds_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  position;
    logic [4:0]  symbol;
    logic [15:0] number;
    logic [2:0]  level;

    modport source (output valid, action, position, symbol, number, level, input ready);
    modport sink (input valid, action, position, symbol, number, level, output ready);
endinterface

interface lds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] command_byte;
    logic       start_before;
    logic       stop_after;
    logic       last;

    modport source (output valid, command_byte, start_before, stop_after, last, input ready);
    modport sink (input valid, command_byte, start_before, stop_after, last, output ready);
endinterface

### rtl/lds_front.sv
// front end: accepts requests, splits numbers into digits, queues commands
// depends on lds_pkg and lds_in_if
`timescale 1ns / 1ps

module lds_front
    import lds_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lds_in_if.sink        in_ch,
    input  logic          point_enable,
    input  lds_q_status_t q_status,
    output logic          push,
    output lds_entry_t    push_entry
);

    lds_front_state_t state_reg, state_next;
    logic [13:0]      rem_reg, rem_next;
    logic [1:0]       idx_reg, idx_next;

    logic [13:0] weight;
    logic [3:0]  digit_val;
    logic [13:0] digit_sub;

    function automatic logic [13:0] mod10000(input logic [15:0] v);
        logic [15:0] sub;
        sub = '0;
        for (int k = 1; k <= 6; k++)
        begin
            if (v >= 16'(k * 10000))
                sub = 16'(k * 10000);
        end
        return 14'(v - sub);
    endfunction

    function automatic logic [7:0] seg_byte(input logic [4:0] sym, input logic pe);
        return seg_lookup(sym) | (pe ? SEG_POINT : SEG_BLANK);
    endfunction

    // current decimal digit: largest k with k * weight not above the remainder
    always_comb
    begin
        weight    = digit_weight(idx_reg);
        digit_val = '0;
        digit_sub = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_reg >= 14'(k) * weight)
            begin
                digit_val = 4'(k);
                digit_sub = 14'(k) * weight;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        push        = 1'b0;
        push_entry  = '{op: OP_SINGLE, addr: 3'd0, data: CMD_DISPLAY_OFF, last: 1'b1};
        in_ch.ready = 1'b0;
        case (state_reg)
            FS_IDLE:
            begin
                in_ch.ready = !q_status.full;
                if (in_ch.valid && !q_status.full)
                begin
                    case (lds_action_t'(in_ch.action))
                        ACT_WRITE_DIGIT:
                        begin
                            push       = 1'b1;
                            push_entry = '{op: OP_DIGIT, addr: in_ch.position - 3'd1,
                                           data: seg_byte(in_ch.symbol, point_enable),
                                           last: 1'b1};
                        end
                        ACT_SHOW_NUMBER:
                        begin
                            rem_next   = mod10000(in_ch.number);
                            idx_next   = '0;
                            state_next = FS_DIGITS;
                        end
                        ACT_SET_BRIGHTNESS:
                        begin
                            push       = 1'b1;
                            push_entry = '{op: OP_SINGLE, addr: 3'd0,
                                           data: CMD_BRIGHT_BASE | {5'd0, in_ch.level},
                                           last: 1'b1};
                        end
                        default:
                        begin
                            push       = 1'b1;
                            push_entry = '{op: OP_SINGLE, addr: 3'd0,
                                           data: CMD_DISPLAY_OFF, last: 1'b1};
                        end
                    endcase
                end
            end
            FS_DIGITS:
            begin
                if (!q_status.full)
                begin
                    push       = 1'b1;
                    push_entry = '{op: OP_DIGIT, addr: {1'b0, idx_reg},
                                   data: seg_byte({1'b0, digit_val}, point_enable),
                                   last: (idx_reg == 2'd3)};
                    rem_next   = rem_reg - digit_sub;
                    idx_next   = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                        state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

endmodule

### rtl/lds_queue.sv
// command queue between front and back end of the led digit sequencer
// depends on lds_pkg
`timescale 1ns / 1ps

module lds_queue
    import lds_pkg::*;
#(
    parameter int DEPTH = LDS_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lds_entry_t    push_entry,
    input  logic          pop,
    output lds_entry_t    head,
    output lds_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lds_entry_t         store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.valid = (cnt_reg != '0);
    assign head         = store_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && !status.full;
        do_pop      = pop && status.valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### rtl/lds_back.sv
// back end: queued commands to framed bytes, one per unstalled cycle
// depends on lds_pkg and lds_out_if
`timescale 1ns / 1ps

module lds_back
    import lds_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  lds_entry_t    head,
    input  lds_q_status_t q_status,
    output logic          pop,
    lds_out_if.source     out_ch
);

    lds_step_t  step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       start_reg, start_next;
    logic       stop_reg, stop_next;
    logic       last_reg, last_next;
    logic       load;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.command_byte = byte_reg;
    assign out_ch.start_before = start_reg;
    assign out_ch.stop_after   = stop_reg;
    assign out_ch.last         = last_reg;

    always_comb
    begin
        load           = !out_valid_reg || out_ch.ready;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        byte_next      = byte_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (q_status.valid && load)
        begin
            out_valid_next = 1'b1;
            if (head.op == OP_SINGLE)
            begin
                byte_next  = head.data;
                start_next = 1'b1;
                stop_next  = 1'b1;
                last_next  = head.last;
                pop        = 1'b1;
            end
            else
            begin
                case (step_reg)
                    STEP_MODE:
                    begin
                        byte_next  = CMD_FIXED_ADDR;
                        start_next = 1'b1;
                        stop_next  = 1'b1;
                        last_next  = 1'b0;
                    end
                    STEP_ADDR:
                    begin
                        byte_next  = CMD_ADDR_BASE | {5'd0, head.addr};
                        start_next = 1'b1;
                        stop_next  = 1'b0;
                        last_next  = 1'b0;
                    end
                    STEP_SEG:
                    begin
                        // segment byte continues the address transaction
                        byte_next  = head.data;
                        start_next = 1'b0;
                        stop_next  = 1'b1;
                        last_next  = 1'b0;
                    end
                    default:
                    begin
                        byte_next  = CMD_DISPLAY_ON;
                        start_next = 1'b1;
                        stop_next  = 1'b1;
                        last_next  = head.last;
                        pop        = 1'b1;
                    end
                endcase
            end
            step_next = pop ? STEP_MODE : lds_step_t'(step_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_MODE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        start_reg <= start_next;
        stop_reg  <= stop_next;
        last_reg  <= last_next;
    end

endmodule

### rtl/led_digit_command_sequencer_core.sv
// top level of the led digit command sequencer: config register, front, queue, back
// depends on lds_pkg, lds_if, lds_front, lds_queue, lds_back
//
// channel   dir  transaction                 payload
// in_ch     in   one display request          action position symbol number level
// out_ch    out  one framed command byte      command_byte start_before stop_after last
// cfg       in   write of point_enable        cfg_wr_en cfg_wr_data
//
// the back end sends one byte per cycle while out_ch does not stall: a digit write is
// 4 bytes, show number 16, brightness and display off 1; the output register sets
// that rate; the front takes a request per cycle while the queue has room; show
// number holds it while its four decimal digits are queued, one per cycle with room
// a request reaches the output register through the queue, show number after the
// digit state as well; out_ch stalls back up via the queue
// reset clears the point enable, the queue and both state machines
`timescale 1ns / 1ps

module led_digit_command_sequencer_core
    import lds_pkg::*;
#(
    parameter int QUEUE_DEPTH = LDS_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    lds_in_if.sink    in_ch,
    lds_out_if.source out_ch,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data
);

    logic          point_enable_reg;
    logic          push;
    logic          pop;
    lds_entry_t    push_entry;
    lds_entry_t    head;
    lds_q_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_enable_reg <= 1'b0;
        else if (cfg_wr_en)
            point_enable_reg <= cfg_wr_data;
    end

    lds_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .point_enable (point_enable_reg),
        .q_status     (q_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    lds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    lds_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

### rtl/lds_checker.sv
// port-level checks on the command byte stream of the led digit sequencer
// depends on led_digit_command_sequencer_core_macros.svh; bound to the top level
`timescale 1ns / 1ps
`include "led_digit_command_sequencer_core_macros.svh"

module lds_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] command_byte,
    input logic       start_before,
    input logic       stop_after,
    input logic       last
);

    // a stalled byte stays offered
    `LDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // the closing byte of every request is a complete framed transaction
    `LDS_ASSERT_SAME(a_last_framed, out_valid && last, start_before && stop_after)

    // a byte without start is a segment byte, which closes its transaction
    `LDS_ASSERT_SAME(a_seg_closes, out_valid && !start_before, stop_after && !last)

    // an opened transaction left without stop carries an address command
    `LDS_ASSERT_SAME(a_addr_open, out_valid && start_before && !stop_after,
                     command_byte[7:3] == 5'b11000)

endmodule

bind led_digit_command_sequencer_core lds_checker u_lds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .command_byte (out_ch.command_byte),
    .start_before (out_ch.start_before),
    .stop_after   (out_ch.stop_after),
    .last         (out_ch.last)
);

### bench/lds_byte_checker.sv
// checker for the led digit command sequencer: watches the request and command byte
// channels and the point enable port, predicts the framed bytes and compares them
// depends on lds_pkg (action codes) and lds_if (channel interfaces)
`timescale 1ns / 1ps

module lds_byte_checker (
    input  logic clk,
    input  logic rst_n,
    lds_in_if    req_mon,
    lds_out_if   cmd_mon,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    output int   fail_count,
    output int   bytes_waiting
);
    import lds_pkg::*;

    localparam logic [7:0] FIXED_ADDR_MODE = 8'h44;
    localparam logic [7:0] ADDR_CMD_BASE   = 8'hC0;
    localparam logic [7:0] DISPLAY_ON_FULL = 8'h8F;
    localparam logic [7:0] BRIGHTNESS_BASE = 8'h88;
    localparam logic [7:0] DISPLAY_OFF_CMD = 8'h80;
    localparam logic [7:0] POINT_SEGMENT   = 8'h80;
    localparam int         GLYPH_COUNT     = 22;

    // segment patterns, entry 0 in the low byte; entry 21 is blank
    localparam logic [8*GLYPH_COUNT-1:0] GLYPHS = {
        8'h00, 8'h3E, 8'h73, 8'h54, 8'h38, 8'h76, 8'h71, 8'h79, 8'h5E, 8'h58, 8'h7C,
        8'h77, 8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic [7:0] code;
        logic       start_mark;
        logic       stop_mark;
        logic       final_byte;
    } framed_byte_t;

    framed_byte_t expected_bytes[$];
    framed_byte_t want;
    logic         point_on;

    function automatic framed_byte_t frame(input logic [7:0] code, input logic start_mark,
                                           input logic stop_mark, input logic final_byte);
        framed_byte_t fb;
        fb.code       = code;
        fb.start_mark = start_mark;
        fb.stop_mark  = stop_mark;
        fb.final_byte = final_byte;
        return fb;
    endfunction

    task automatic queue_digit_write(input logic [2:0] pos, input logic [4:0] sym,
                                     input logic is_last);
        logic [7:0] seg;
        logic [2:0] addr;
        seg = (sym < GLYPH_COUNT) ? GLYPHS[sym*8 +: 8] : 8'h00;
        if (point_on)
            seg = seg | POINT_SEGMENT;
        // out-of-range positions wrap within the three address bits
        addr = pos - 3'd1;
        expected_bytes.push_back(frame(FIXED_ADDR_MODE, 1'b1, 1'b1, 1'b0));
        expected_bytes.push_back(frame(ADDR_CMD_BASE | {5'd0, addr}, 1'b1, 1'b0, 1'b0));
        expected_bytes.push_back(frame(seg, 1'b0, 1'b1, 1'b0));
        expected_bytes.push_back(frame(DISPLAY_ON_FULL, 1'b1, 1'b1, is_last));
    endtask

    task automatic queue_request(input lds_action_t act, input logic [2:0] pos,
                                 input logic [4:0] sym, input logic [15:0] number,
                                 input logic [2:0] level);
        int unsigned rest;
        logic [4:0]  digit_sym [4];
        case (act)
            ACT_WRITE_DIGIT:
                queue_digit_write(pos, sym, 1'b1);
            ACT_SHOW_NUMBER:
            begin
                rest = number % 10000;
                for (int i = 3; i >= 0; i--)
                begin
                    digit_sym[i] = 5'(rest % 10);
                    rest = rest / 10;
                end
                for (int i = 0; i < 4; i++)
                    queue_digit_write(3'(i + 1), digit_sym[i], i == 3);
            end
            ACT_SET_BRIGHTNESS:
                expected_bytes.push_back(frame(BRIGHTNESS_BASE | {5'd0, level},
                                               1'b1, 1'b1, 1'b1));
            default:
                expected_bytes.push_back(frame(DISPLAY_OFF_CMD, 1'b1, 1'b1, 1'b1));
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_on <= 1'b0;
            expected_bytes.delete();
            fail_count    <= 0;
            bytes_waiting <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                point_on <= cfg_wr_data;
            if (req_mon.valid && req_mon.ready)
                queue_request(lds_action_t'(req_mon.action), req_mon.position,
                              req_mon.symbol, req_mon.number, req_mon.level);
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("command byte %h arrived with nothing expected",
                           cmd_mon.command_byte);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (cmd_mon.command_byte !== want.code)
                        $error("command_byte: expected %h, got %h",
                               want.code, cmd_mon.command_byte);
                    if (cmd_mon.start_before !== want.start_mark)
                        $error("start_before: expected %b, got %b",
                               want.start_mark, cmd_mon.start_before);
                    if (cmd_mon.stop_after !== want.stop_mark)
                        $error("stop_after: expected %b, got %b",
                               want.stop_mark, cmd_mon.stop_after);
                    if (cmd_mon.last !== want.final_byte)
                        $error("last: expected %b, got %b", want.final_byte, cmd_mon.last);
                    if (cmd_mon.command_byte !== want.code
                        || cmd_mon.start_before !== want.start_mark
                        || cmd_mon.stop_after !== want.stop_mark
                        || cmd_mon.last !== want.final_byte)
                        fail_count <= fail_count + 1;
                end
            end
            bytes_waiting <= expected_bytes.size();
        end
    end

endmodule

### bench/testbench.sv
// top of the led digit command sequencer bench: clock, reset, request and point enable
// stimulus, output back-pressure and the verdict
// depends on lds_pkg, lds_if, led_digit_command_sequencer_core and lds_byte_checker
`timescale 1ns / 1ps

module testbench;
    import lds_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;
    localparam int PHASE_ITEMS  = 52;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    logic calm;
    int   fail_count;
    int   bytes_waiting;
    int   cycle_count = 0;
    int   hold_cycles;
    int   stall_draw;
    int   bytes_taken;
    int   cfg_writes = 0;
    int   action_count [4] = '{0, 0, 0, 0};

    lds_in_if  req_ch ();
    lds_out_if cmd_ch ();

    led_digit_command_sequencer_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (req_ch),
        .out_ch     (cmd_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    lds_byte_checker byte_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_mon      (req_ch),
        .cmd_mon      (cmd_ch),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .bytes_waiting(bytes_waiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: after each transaction it may hold ready low for a random stall, never while calm
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.ready <= 1'b0;
            hold_cycles  <= 0;
            bytes_taken  <= 0;
        end
        else if (cmd_ch.valid && cmd_ch.ready)
        begin
            stall_draw = calm ? 0 : $urandom_range(0, 3);
            bytes_taken  <= bytes_taken + 1;
            hold_cycles  <= stall_draw;
            cmd_ch.ready <= (stall_draw == 0);
        end
        else if (hold_cycles > 1)
            hold_cycles <= hold_cycles - 1;
        else
        begin
            hold_cycles  <= 0;
            cmd_ch.ready <= 1'b1;
        end
    end

    task automatic send_request(input lds_action_t act, input logic [2:0] pos,
                                input logic [4:0] sym, input logic [15:0] num,
                                input logic [2:0] lvl);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.symbol   <= sym;
        req_ch.number   <= num;
        req_ch.level    <= lvl;
        do
            @(posedge clk);
        while (!req_ch.ready);
        action_count[act]++;
    endtask

    task automatic random_request();
        lds_action_t act;
        logic [2:0]  pos;
        logic [15:0] num;
        act = lds_action_t'(2'($urandom_range(0, 3)));
        // mostly legal positions, now and then the wrapping ones
        if ($urandom_range(0, 7) == 0)
            pos = 3'($urandom_range(0, 7));
        else
            pos = 3'($urandom_range(1, 6));
        if ($urandom_range(0, 1) != 0)
            num = 16'($urandom);
        else
            num = 16'($urandom_range(0, 9999));
        send_request(act, pos, 5'($urandom), num, 3'($urandom));
    endtask

    // all expected bytes out, then a settling wait for the pipeline to empty
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (bytes_waiting != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_point_enable(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 1'b0;
        calm            = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_WRITE_DIGIT;
        req_ch.position = 3'd0;
        req_ch.symbol   = 5'd0;
        req_ch.number   = 16'd0;
        req_ch.level    = 3'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every glyph, wrapping positions, blank symbols, number corners
        send_request(ACT_WRITE_DIGIT, 3'd1, 5'd0, 16'($urandom), 3'($urandom));
        for (int s = 10; s <= 20; s++)
            send_request(ACT_WRITE_DIGIT, 3'(s % 6 + 1), 5'(s), 16'($urandom),
                         3'($urandom));
        send_request(ACT_WRITE_DIGIT, 3'd0, 5'd21, 16'($urandom), 3'($urandom));
        send_request(ACT_WRITE_DIGIT, 3'd7, 5'd31, 16'($urandom), 3'($urandom));
        send_request(ACT_SHOW_NUMBER, 3'($urandom), 5'($urandom), 16'd0, 3'($urandom));
        send_request(ACT_SHOW_NUMBER, 3'($urandom), 5'($urandom), 16'd1234, 3'($urandom));
        send_request(ACT_SHOW_NUMBER, 3'($urandom), 5'($urandom), 16'd65535, 3'($urandom));
        send_request(ACT_SHOW_NUMBER, 3'($urandom), 5'($urandom), 16'd10000, 3'($urandom));
        send_request(ACT_SHOW_NUMBER, 3'($urandom), 5'($urandom), 16'd9876, 3'($urandom));
        send_request(ACT_SHOW_NUMBER, 3'($urandom), 5'($urandom), 16'd9999, 3'($urandom));
        send_request(ACT_SET_BRIGHTNESS, 3'($urandom), 5'($urandom), 16'($urandom), 3'd0);
        send_request(ACT_SET_BRIGHTNESS, 3'($urandom), 5'($urandom), 16'($urandom), 3'd7);
        send_request(ACT_DISPLAY_OFF, 3'($urandom), 5'($urandom), 16'($urandom),
                     3'($urandom));

        // random phases with the point enable toggled between them; phase 2 runs flat out
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_until_drained();
            write_point_enable(phase % 2 == 0);
            calm = (phase == 2);
            repeat (PHASE_ITEMS) random_request();
        end
        calm = 1'b0;
        wait_until_drained();

        $display("%0d requests: %0d digit writes, %0d numbers, %0d brightness, %0d off",
                 action_count[0] + action_count[1] + action_count[2] + action_count[3],
                 action_count[0], action_count[1], action_count[2], action_count[3]);
        $display("%0d command bytes checked across %0d point enable settings",
                 bytes_taken, cfg_writes + 1);
        if (fail_count == 0 && bytes_waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/lds_pkg.sv
rtl/lds_if.sv
rtl/lds_front.sv
rtl/lds_queue.sv
rtl/lds_back.sv
rtl/led_digit_command_sequencer_core.sv
rtl/lds_checker.sv
bench/lds_byte_checker.sv
bench/testbench.sv
